[hw/rtl/u8up_pkg.sv]
// ----------------------------------------------------------------------------
// u8up_pkg
// Shared types and constants of the UTF-8 uppercase mapper.
// ----------------------------------------------------------------------------
package u8up_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned MaxGroup = 4;
    localparam int unsigned CntW     = 3;

    localparam logic [ByteW-1:0] LeadMin  = 8'hc0;
    localparam logic [ByteW-1:0] LeadE1   = 8'he1;
    localparam logic [ByteW-1:0] LeadE2   = 8'he2;
    localparam logic [ByteW-1:0] LeadEa   = 8'hea;
    localparam logic [ByteW-1:0] LeadEf   = 8'hef;
    localparam logic [ByteW-1:0] LeadF0   = 8'hf0;
    localparam logic [ByteW-1:0] AsciiA   = 8'h61;
    localparam logic [ByteW-1:0] AsciiZ   = 8'h7a;
    localparam logic [ByteW-1:0] CaseStep = 8'h20;

    typedef logic [ByteW-1:0] t_byte;

    typedef struct packed {
        t_byte b0;
        t_byte b1;
        t_byte b2;
        t_byte b3;
    } t_group;

    function automatic logic rng(input t_byte x, input t_byte lo, input t_byte hi);
        rng = (x >= lo) && (x <= hi);
    endfunction

endpackage

[hw/rtl/u8up_if.sv]
// ----------------------------------------------------------------------------
// u8up_if
// Valid/ready channel carrying one byte word and its end mark.
// ----------------------------------------------------------------------------
interface u8up_if;
    logic           valid;
    logic           ready;
    u8up_pkg::t_byte data;
    logic           last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

[hw/rtl/utf8_uppercase_mapper.sv]
// ----------------------------------------------------------------------------
// utf8_uppercase_mapper
// A standalone byte leaves in the cycle after it is taken, and a group leaves
// as a burst from the cycle after its last byte is taken. Input takes one byte
// word per cycle, but stalls while the burst register holds more than one word
// or its last word is not taken; one word drains per cycle while o_out.ready.
// Reset (synchronous, active low) closes any open group and empties output.
// ----------------------------------------------------------------------------
module utf8_uppercase_mapper (
    input  logic   i_clk,
    input  logic   i_rst_n,
    u8up_if.sink   i_in,
    u8up_if.source o_out
);
    // Group collection state.
    u8up_pkg::t_byte r_g0, r_g1, r_g2;
    logic [2:0]      r_len, n_len;
    logic [1:0]      r_held, n_held;

    // Output burst register: up to four words, shifted out from b0.
    u8up_pkg::t_group r_ob, n_ob;
    logic [2:0]       r_ocnt, n_ocnt;
    logic             r_oend, n_oend;

    logic             take, emit;
    logic [2:0]       len_eff, emit_n;
    u8up_pkg::t_group grp, mapped, raw;
    u8up_pkg::t_byte  b, ab;

    u8up_map u_map (.i_grp(grp), .i_len(len_eff), .o_grp(mapped));

    assign b = i_in.data;
    // Accept when the burst register is empty or finishing its last word.
    assign i_in.ready  = (r_ocnt == 3'd0) || (r_ocnt == 3'd1 && o_out.ready);
    assign take        = i_in.valid && i_in.ready;
    assign o_out.valid = (r_ocnt != 3'd0);
    assign o_out.data  = r_ob.b0;
    assign o_out.last  = r_oend && (r_ocnt == 3'd1);

    always_comb begin
        // Short four-byte group: lead F0 with an unexpected second byte.
        len_eff = r_len;
        if (r_g0 == u8up_pkg::LeadF0 && r_held == 2'd1 && b != 8'h90 && b != 8'h91 &&
            b != 8'h96 && b != 8'h9e) len_eff = 3'd2;
        raw = '{r_g0, r_g1, r_g2, 8'h00};
        case (r_held)
            2'd1:    raw.b1 = b;
            2'd2:    raw.b2 = b;
            default: raw.b3 = b;
        endcase
        grp = raw;
        ab  = b;
        if (u8up_pkg::rng(b, u8up_pkg::AsciiA, u8up_pkg::AsciiZ)) ab = b - u8up_pkg::CaseStep;

        n_len  = r_len;
        n_held = r_held;
        emit   = 1'b0;
        emit_n = 3'd1;
        n_ob   = r_ob;
        if (r_held == 2'd0) begin
            n_ob.b0 = ab;
            if (b > u8up_pkg::LeadMin && !i_in.last) begin
                n_held = 2'd1;
                n_len  = (b == u8up_pkg::LeadE1 || b == u8up_pkg::LeadE2 ||
                          b == u8up_pkg::LeadEa || b == u8up_pkg::LeadEf) ? 3'd3 :
                         (b == u8up_pkg::LeadF0) ? 3'd4 : 3'd2;
            end else begin
                emit = 1'b1;
                if (b > u8up_pkg::LeadMin) n_ob.b0 = b;
            end
        end else if ({1'b0, r_held} + 3'd1 >= len_eff) begin
            emit   = 1'b1;
            emit_n = {1'b0, r_held} + 3'd1;
            n_ob   = mapped;
            n_held = 2'd0;
            n_len  = 3'd0;
        end else if (i_in.last) begin
            emit   = 1'b1;
            emit_n = {1'b0, r_held} + 3'd1;
            n_ob   = raw;
            n_held = 2'd0;
            n_len  = 3'd0;
        end else begin
            n_held = r_held + 2'd1;
        end

        // Advance the burst register.
        n_ocnt = r_ocnt;
        n_oend = r_oend;
        if (!(take && emit)) n_ob = r_ob;
        if (o_out.valid && o_out.ready) begin
            n_ocnt = r_ocnt - 3'd1;
            if (!(take && emit)) n_ob = '{r_ob.b1, r_ob.b2, r_ob.b3, 8'h00};
        end
        if (take && emit) begin
            n_ocnt = emit_n;
            n_oend = i_in.last;
        end
        if (!take) begin
            n_held = r_held;
            n_len  = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 2'd0;
            r_len  <= 3'd0;
            r_ocnt <= 3'd0;
            r_oend <= 1'b0;
        end else begin
            r_held <= n_held;
            r_len  <= n_len;
            r_ocnt <= n_ocnt;
            r_oend <= n_oend;
        end
        r_ob <= n_ob;
        if (take && r_held == 2'd0) r_g0 <= b;
        if (take && r_held == 2'd1) r_g1 <= b;
        if (take && r_held == 2'd2) r_g2 <= b;
    end
endmodule

[hw/rtl/u8up_map.sv]
// ----------------------------------------------------------------------------
// u8up_map
// Case tables: rewrite a complete two-, three- or four-byte group.
// ----------------------------------------------------------------------------
module u8up_map (
    input  u8up_pkg::t_group i_grp,
    input  logic [2:0]       i_len,
    output u8up_pkg::t_group o_grp
);
    function automatic u8up_pkg::t_group map2(input u8up_pkg::t_group g);
        logic [7:0] l;
        logic [7:0] c;
        l = g.b0;
        c = g.b1;
        case (l)
            8'hc3: begin
                if (u8up_pkg::rng(c, 8'ha0, 8'hbe) && c != 8'hb7) c = c - 8'h20;
                else if (c == 8'hbf) begin l = 8'hc5; c = 8'hb8; end
            end
            8'hc4: begin
                if ((u8up_pkg::rng(c, 8'h80, 8'hb7) && c[0]) ||
                    (u8up_pkg::rng(c, 8'hb9, 8'hbe) && !c[0])) c = c - 8'h01;
            end
            8'hc5: begin
                if (c == 8'h80) begin l = 8'hc4; c = 8'hbf; end
                else if ((u8up_pkg::rng(c, 8'h81, 8'h88) && !c[0]) ||
                         (u8up_pkg::rng(c, 8'h8a, 8'hb7) && c[0]) ||
                         (u8up_pkg::rng(c, 8'hb9, 8'hbe) && !c[0])) c = c - 8'h01;
            end
            8'hc6: begin
                case (c)
                    8'h83, 8'h85, 8'h88, 8'h8c, 8'h92, 8'h99, 8'ha1, 8'ha3,
                    8'ha5, 8'ha8, 8'had, 8'hb0, 8'hb4, 8'hb6, 8'hb9, 8'hbd:
                        c = c - 8'h01;
                    8'h80: begin l = 8'hc9; c = 8'h83; end
                    8'h95: begin l = 8'hc7; c = 8'hb6; end
                    8'h9a: begin l = 8'hc8; c = 8'hbd; end
                    8'h9e: begin l = 8'hc8; c = 8'ha0; end
                    default: ;
                endcase
            end
            8'hc7: begin
                if (c == 8'h86) c = 8'h84;
                else if (c == 8'h89) c = 8'h87;
                else if (c == 8'h8c) c = 8'h8a;
                else if (c == 8'hb3) c = 8'hb1;
                else if (c == 8'h85 || c == 8'h88 || c == 8'h8b || c == 8'hb2 ||
                         c == 8'hb5 || (u8up_pkg::rng(c, 8'h8d, 8'h9c) && !c[0]) ||
                         (u8up_pkg::rng(c, 8'h9e, 8'haf) && c[0]) ||
                         (u8up_pkg::rng(c, 8'hb9, 8'hbf) && c[0])) c = c - 8'h01;
            end
            8'hc8: begin
                if ((u8up_pkg::rng(c, 8'h80, 8'h9f) && c[0]) ||
                    (u8up_pkg::rng(c, 8'ha2, 8'hb3) && c[0]) || c == 8'hbc)
                    c = c - 8'h01;
            end
            8'hc9: begin
                case (c)
                    8'h82: c = 8'h81;
                    8'h93: begin l = 8'hc6; c = 8'h81; end
                    8'h94: begin l = 8'hc6; c = 8'h86; end
                    8'h97: begin l = 8'hc6; c = 8'h8a; end
                    8'h98: begin l = 8'hc6; c = 8'h8e; end
                    8'h99: begin l = 8'hc6; c = 8'h8f; end
                    8'h9b: begin l = 8'hc6; c = 8'h90; end
                    8'ha0: begin l = 8'hc6; c = 8'h93; end
                    8'ha3: begin l = 8'hc6; c = 8'h94; end
                    8'ha8: begin l = 8'hc6; c = 8'h97; end
                    8'ha9: begin l = 8'hc6; c = 8'h96; end
                    8'haf: begin l = 8'hc6; c = 8'h9c; end
                    8'hb2: begin l = 8'hc6; c = 8'h9d; end
                    default: if (u8up_pkg::rng(c, 8'h87, 8'h8f) && c[0]) c = c - 8'h01;
                endcase
            end
            8'hca: begin
                case (c)
                    8'h83: begin l = 8'hc6; c = 8'ha9; end
                    8'h88: begin l = 8'hc6; c = 8'hae; end
                    8'h89: begin l = 8'hc9; c = 8'h84; end
                    8'h8a: begin l = 8'hc6; c = 8'hb1; end
                    8'h8b: begin l = 8'hc6; c = 8'hb2; end
                    8'h8c: begin l = 8'hc9; c = 8'h85; end
                    8'h92: begin l = 8'hc6; c = 8'hb7; end
                    default: ;
                endcase
            end
            8'hcd: begin
                if (c == 8'hb1 || c == 8'hb3 || c == 8'hb7) c = c - 8'h01;
                else if (u8up_pkg::rng(c, 8'hbb, 8'hbd)) begin l = 8'hcf; c = c + 8'h02; end
            end
            8'hce: begin
                if (c == 8'hac) c = 8'h86;
                else if (u8up_pkg::rng(c, 8'had, 8'haf)) c = c - 8'h25;
                else if (u8up_pkg::rng(c, 8'hb1, 8'hbf)) c = c - 8'h20;
            end
            8'hcf: begin
                if (u8up_pkg::rng(c, 8'h80, 8'h8b)) begin l = 8'hce; c = c + 8'h20; end
                else if (c == 8'h8c) l = 8'hce;
                else if (c == 8'h8d || c == 8'h8e) begin l = 8'hce; c = c + 8'h01; end
                else if (c == 8'h91) c = 8'hb4;
                else if (c == 8'h97) c = 8'h8f;
                else if ((u8up_pkg::rng(c, 8'h98, 8'haf) && c[0]) || c == 8'hb8 ||
                         c == 8'hbb) c = c - 8'h01;
                else if (c == 8'hb2) c = 8'hb9;
                else if (c == 8'hb3) begin l = 8'hcd; c = 8'hbf; end
            end
            8'hd0: if (u8up_pkg::rng(c, 8'hb0, 8'hbf)) c = c - 8'h20;
            8'hd1: begin
                if (u8up_pkg::rng(c, 8'h80, 8'h8f)) begin l = 8'hd0; c = c + 8'h20; end
                else if (u8up_pkg::rng(c, 8'h90, 8'h9f)) begin l = 8'hd0; c = c - 8'h10; end
                else if (u8up_pkg::rng(c, 8'ha0, 8'hbf) && c[0]) c = c - 8'h01;
            end
            8'hd2: if (c == 8'h81 || (u8up_pkg::rng(c, 8'h8a, 8'hbf) && c[0])) c = c - 8'h01;
            8'hd3: begin
                if ((u8up_pkg::rng(c, 8'h81, 8'h8e) && !c[0]) ||
                    (u8up_pkg::rng(c, 8'h90, 8'hbf) && c[0])) c = c - 8'h01;
                else if (c == 8'h8f) c = 8'h80;
            end
            8'hd4: if (u8up_pkg::rng(c, 8'h80, 8'haf) && c[0]) c = c - 8'h01;
            8'hd5: begin
                if (u8up_pkg::rng(c, 8'ha1, 8'haf)) begin l = 8'hd4; c = c + 8'h10; end
                else if (u8up_pkg::rng(c, 8'hb0, 8'hbf)) c = c - 8'h30;
            end
            8'hd6: if (u8up_pkg::rng(c, 8'h80, 8'h86)) begin l = 8'hd5; c = c + 8'h10; end
            default: ;
        endcase
        map2 = g;
        map2.b0 = l;
        map2.b1 = c;
    endfunction

    function automatic logic greek8(input logic [7:0] t);
        greek8 = u8up_pkg::rng(t, 8'h80, 8'h87) || u8up_pkg::rng(t, 8'h90, 8'h97) ||
                 u8up_pkg::rng(t, 8'ha0, 8'ha7);
    endfunction

    function automatic u8up_pkg::t_group map3(input u8up_pkg::t_group g);
        logic [7:0] l;
        logic [7:0] s;
        logic [7:0] t;
        l = g.b0;
        s = g.b1;
        t = g.b2;
        if (l == u8up_pkg::LeadE1) begin
            case (s)
                8'h83: if (u8up_pkg::rng(t, 8'h90, 8'hba) || u8up_pkg::rng(t, 8'hbd, 8'hbf))
                    s = 8'hb2;
                8'h8f: if (u8up_pkg::rng(t, 8'hb8, 8'hbd)) t = t - 8'h08;
                8'hb6: if (t == 8'h8e) begin l = 8'hea; s = 8'h9f; t = 8'h86; end
                8'hb8, 8'hb9, 8'hbb: if (u8up_pkg::rng(t, 8'h80, 8'hbf) && t[0]) t = t - 8'h01;
                8'hba: if ((u8up_pkg::rng(t, 8'h80, 8'h93) || u8up_pkg::rng(t, 8'ha0, 8'hbf))
                           && t[0]) t = t - 8'h01;
                8'hbc: if (greek8(t) || u8up_pkg::rng(t, 8'hb0, 8'hb7)) t = t + 8'h08;
                8'hbd: begin
                    if (u8up_pkg::rng(t, 8'h80, 8'h87) ||
                        (u8up_pkg::rng(t, 8'h90, 8'h97) && t[0]) ||
                        u8up_pkg::rng(t, 8'ha0, 8'ha7)) t = t + 8'h08;
                    else if (u8up_pkg::rng(t, 8'hb0, 8'hb1)) begin s = 8'hbe; t = t + 8'h0a; end
                    else if (u8up_pkg::rng(t, 8'hb2, 8'hb5)) begin s = 8'hbf; t = t - 8'h2a; end
                    else if (u8up_pkg::rng(t, 8'hb6, 8'hb7)) begin s = 8'hbf; t = t - 8'h1e; end
                    else if (u8up_pkg::rng(t, 8'hb8, 8'hb9)) s = 8'hbf;
                    else if (u8up_pkg::rng(t, 8'hba, 8'hbb)) begin s = 8'hbf; t = t - 8'h10; end
                    else if (u8up_pkg::rng(t, 8'hbc, 8'hbd)) begin s = 8'hbf; t = t - 8'h02; end
                end
                8'hbe: begin
                    if (greek8(t) || u8up_pkg::rng(t, 8'hb0, 8'hb1)) t = t + 8'h08;
                    else if (t == 8'hb3) t = t + 8'h09;
                end
                8'hbf: begin
                    if (t == 8'h83 || t == 8'hb3) t = t + 8'h09;
                    else if (u8up_pkg::rng(t, 8'h90, 8'h91) || u8up_pkg::rng(t, 8'ha0, 8'ha1))
                        t = t + 8'h08;
                    else if (t == 8'ha5) t = t + 8'h07;
                end
                default: ;
            endcase
        end else if (l == u8up_pkg::LeadE2) begin
            case (s)
                8'hb0: if (u8up_pkg::rng(t, 8'hb0, 8'hbf)) t = t - 8'h30;
                8'hb1: begin
                    if (u8up_pkg::rng(t, 8'h80, 8'h9e)) begin s = 8'hb0; t = t + 8'h10; end
                    else if (t == 8'ha1 || t == 8'ha8 || t == 8'haa || t == 8'hac ||
                             t == 8'hb3 || t == 8'hb6) t = t - 8'h01;
                end
                8'hb2: if (u8up_pkg::rng(t, 8'h80, 8'hbf) && t[0]) t = t - 8'h01;
                8'hb3: if ((u8up_pkg::rng(t, 8'h80, 8'ha3) && t[0]) || t == 8'hac ||
                           t == 8'hae || t == 8'hb3) t = t - 8'h01;
                default: ;
            endcase
        end else if (l == u8up_pkg::LeadEa) begin
            case (s)
                8'h99: if (u8up_pkg::rng(t, 8'h80, 8'had) && t[0]) t = t - 8'h01;
                8'h9a: if (u8up_pkg::rng(t, 8'h80, 8'h9b) && t[0]) t = t - 8'h01;
                8'h9c: if ((u8up_pkg::rng(t, 8'ha2, 8'haf) || u8up_pkg::rng(t, 8'hb2, 8'hbf))
                           && t[0]) t = t - 8'h01;
                8'h9d: if ((u8up_pkg::rng(t, 8'h80, 8'haf) && t[0]) || t == 8'hba ||
                           t == 8'hbc || t == 8'hbf) t = t - 8'h01;
                8'h9e: begin
                    if (((u8up_pkg::rng(t, 8'h80, 8'h87) || u8up_pkg::rng(t, 8'h96, 8'ha9) ||
                          u8up_pkg::rng(t, 8'hb4, 8'hbf)) && t[0]) ||
                        t == 8'h8c || t == 8'h91 || t == 8'h93) t = t - 8'h01;
                    else if (t == 8'h94) begin s = 8'h9f; t = 8'h84; end
                end
                8'h9f: if (t == 8'h83 || t == 8'h88 || t == 8'h8a || t == 8'hb6) t = t - 8'h01;
                8'had: begin
                    if (t == 8'h93) begin s = 8'h9e; t = 8'hb3; end
                    else if (u8up_pkg::rng(t, 8'hb0, 8'hbf)) begin
                        l = 8'he1; s = 8'h8e; t = t - 8'h10;
                    end
                end
                8'hae: begin
                    if (u8up_pkg::rng(t, 8'h80, 8'h8f)) begin
                        l = 8'he1; s = 8'h8e; t = t + 8'h30;
                    end else if (u8up_pkg::rng(t, 8'h90, 8'hbf)) begin
                        l = 8'he1; s = 8'h8f; t = t - 8'h10;
                    end
                end
                default: ;
            endcase
        end else if (l == u8up_pkg::LeadEf) begin
            if (s == 8'hbd && u8up_pkg::rng(t, 8'h81, 8'h9a)) begin s = 8'hbc; t = t + 8'h20; end
        end
        map3 = g;
        map3.b0 = l;
        map3.b1 = s;
        map3.b2 = t;
    endfunction

    function automatic u8up_pkg::t_group map4(input u8up_pkg::t_group g);
        logic [7:0] s;
        logic [7:0] t;
        logic [7:0] u;
        s = g.b1;
        t = g.b2;
        u = g.b3;
        if (s == 8'h90) begin
            if (t == 8'h90) begin
                if (u8up_pkg::rng(u, 8'ha8, 8'hbf)) u = u - 8'h28;
            end else if (t == 8'h91) begin
                if (u8up_pkg::rng(u, 8'h80, 8'h8f)) begin t = 8'h90; u = u + 8'h18; end
            end else if (t == 8'h93) begin
                if (u8up_pkg::rng(u, 8'h98, 8'ha7)) begin t = 8'h92; u = u + 8'h18; end
                else if (u8up_pkg::rng(u, 8'ha8, 8'hbb)) u = u - 8'h28;
            end else if (t == 8'hb3) begin
                if (u8up_pkg::rng(u, 8'h80, 8'hb2)) t = 8'hb2;
            end
        end else if (s == 8'h91) begin
            if (t == 8'ha3 && u8up_pkg::rng(u, 8'h80, 8'h9f)) begin t = 8'ha2; u = u + 8'h20; end
        end else if (s == 8'h96) begin
            if (t == 8'hb9 && u8up_pkg::rng(u, 8'ha0, 8'hbf)) u = u - 8'h20;
        end else if (s == 8'h9e) begin
            if (t == 8'ha4) begin
                if (u8up_pkg::rng(u, 8'ha2, 8'hbf)) u = u - 8'h22;
            end else if (t == 8'ha5) begin
                if (u8up_pkg::rng(u, 8'h80, 8'h83)) begin t = 8'ha4; u = u + 8'h1e; end
            end
        end
        map4 = g;
        map4.b2 = t;
        map4.b3 = u;
    endfunction

    always_comb begin
        case (i_len)
            3'd2:    o_grp = (i_grp.b0 == u8up_pkg::LeadF0) ? i_grp : map2(i_grp);
            3'd3:    o_grp = map3(i_grp);
            3'd4:    o_grp = map4(i_grp);
            default: o_grp = i_grp;
        endcase
    end
endmodule

[test/tb_utf8_uppercase_mapper.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_uppercase_mapper
// Drives byte strings into the uppercase mapper and checks every output word
// against an in-bench case-mapping predictor. Covers ASCII, two-, three- and
// four-byte groups, short four-byte groups, partial groups flushed at the end
// of a string, random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_utf8_uppercase_mapper;
    import u8up_pkg::*;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_word;

    logic clk;
    logic rst_n;

    u8up_if in_ch ();
    u8up_if out_ch ();

    utf8_uppercase_mapper dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predictor state: open group bytes, its length and bytes held so far.
    t_byte     grp_bytes [3];
    int        grp_len;
    int        grp_held;
    t_word     upper_q [$];
    int        fail_count;
    bit        steady;      // suppress random idling on both sides
    int        hold_left;   // cycles the receiver still holds off

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Case-mapping predictor
    // ------------------------------------------------------------------------
    function automatic bit span(input int x, input int lo, input int hi);
        return x >= lo && x <= hi;
    endfunction

    function automatic bit is_odd(input int x);
        return x[0];
    endfunction

    // Rewrite a two-byte group in place.
    function automatic void fold_two(ref t_byte g [4]);
        int l;
        int c;
        l = g[0];
        c = g[1];
        case (l)
            'hc3: begin
                if (span(c, 'ha0, 'hbe) && c != 'hb7) c -= 'h20;
                else if (c == 'hbf) begin l = 'hc5; c = 'hb8; end
            end
            'hc4: begin
                if ((span(c, 'h80, 'hb7) && is_odd(c)) || (span(c, 'hb9, 'hbe) && !is_odd(c)))
                    c--;
            end
            'hc5: begin
                if (c == 'h80) begin l = 'hc4; c = 'hbf; end
                else if ((span(c, 'h81, 'h88) && !is_odd(c)) ||
                         (span(c, 'h8a, 'hb7) && is_odd(c)) ||
                         (span(c, 'hb9, 'hbe) && !is_odd(c))) c--;
            end
            'hc6: begin
                case (c)
                    'h83, 'h85, 'h88, 'h8c, 'h92, 'h99, 'ha1, 'ha3, 'ha5, 'ha8, 'had,
                    'hb0, 'hb4, 'hb6, 'hb9, 'hbd: c--;
                    'h80: begin l = 'hc9; c = 'h83; end
                    'h95: begin l = 'hc7; c = 'hb6; end
                    'h9a: begin l = 'hc8; c = 'hbd; end
                    'h9e: begin l = 'hc8; c = 'ha0; end
                    default: ;
                endcase
            end
            'hc7: begin
                if (c == 'h86) c = 'h84;
                else if (c == 'h89) c = 'h87;
                else if (c == 'h8c) c = 'h8a;
                else if (c == 'hb3) c = 'hb1;
                else if (c == 'h85 || c == 'h88 || c == 'h8b || c == 'hb2 || c == 'hb5 ||
                         (span(c, 'h8d, 'h9c) && !is_odd(c)) ||
                         (span(c, 'h9e, 'haf) && is_odd(c)) ||
                         (span(c, 'hb9, 'hbf) && is_odd(c))) c--;
            end
            'hc8: begin
                if ((span(c, 'h80, 'h9f) && is_odd(c)) || (span(c, 'ha2, 'hb3) && is_odd(c)) ||
                    c == 'hbc) c--;
            end
            'hc9: begin
                case (c)
                    'h82: c--;
                    'h93: begin l = 'hc6; c = 'h81; end
                    'h94: begin l = 'hc6; c = 'h86; end
                    'h97: begin l = 'hc6; c = 'h8a; end
                    'h98: begin l = 'hc6; c = 'h8e; end
                    'h99: begin l = 'hc6; c = 'h8f; end
                    'h9b: begin l = 'hc6; c = 'h90; end
                    'ha0: begin l = 'hc6; c = 'h93; end
                    'ha3: begin l = 'hc6; c = 'h94; end
                    'ha8: begin l = 'hc6; c = 'h97; end
                    'ha9: begin l = 'hc6; c = 'h96; end
                    'haf: begin l = 'hc6; c = 'h9c; end
                    'hb2: begin l = 'hc6; c = 'h9d; end
                    default: if (span(c, 'h87, 'h8f) && is_odd(c)) c--;
                endcase
            end
            'hca: begin
                case (c)
                    'h83: begin l = 'hc6; c = 'ha9; end
                    'h88: begin l = 'hc6; c = 'hae; end
                    'h89: begin l = 'hc9; c = 'h84; end
                    'h8a: begin l = 'hc6; c = 'hb1; end
                    'h8b: begin l = 'hc6; c = 'hb2; end
                    'h8c: begin l = 'hc9; c = 'h85; end
                    'h92: begin l = 'hc6; c = 'hb7; end
                    default: ;
                endcase
            end
            'hcd: begin
                if (c == 'hb1 || c == 'hb3 || c == 'hb7) c--;
                else if (span(c, 'hbb, 'hbd)) begin l = 'hcf; c += 'h02; end
            end
            'hce: begin
                if (c == 'hac) c = 'h86;
                else if (span(c, 'had, 'haf)) c -= 'h25;
                else if (span(c, 'hb1, 'hbf)) c -= 'h20;
            end
            'hcf: begin
                if (span(c, 'h80, 'h8b)) begin l = 'hce; c += 'h20; end
                else if (c == 'h8c) l = 'hce;
                else if (c == 'h8d || c == 'h8e) begin l = 'hce; c += 'h01; end
                else if (c == 'h91) c = 'hb4;
                else if (c == 'h97) c = 'h8f;
                else if ((span(c, 'h98, 'haf) && is_odd(c)) || c == 'hb8 || c == 'hbb) c--;
                else if (c == 'hb2) c = 'hb9;
                else if (c == 'hb3) begin l = 'hcd; c = 'hbf; end
            end
            'hd0: if (span(c, 'hb0, 'hbf)) c -= 'h20;
            'hd1: begin
                if (span(c, 'h80, 'h8f)) begin l = 'hd0; c += 'h20; end
                else if (span(c, 'h90, 'h9f)) begin l = 'hd0; c -= 'h10; end
                else if (span(c, 'ha0, 'hbf) && is_odd(c)) c--;
            end
            'hd2: if (c == 'h81 || (span(c, 'h8a, 'hbf) && is_odd(c))) c--;
            'hd3: begin
                if ((span(c, 'h81, 'h8e) && !is_odd(c)) || (span(c, 'h90, 'hbf) && is_odd(c)))
                    c--;
                else if (c == 'h8f) c = 'h80;
            end
            'hd4: if (span(c, 'h80, 'haf) && is_odd(c)) c--;
            'hd5: begin
                if (span(c, 'ha1, 'haf)) begin l = 'hd4; c += 'h10; end
                else if (span(c, 'hb0, 'hbf)) c -= 'h30;
            end
            'hd6: if (span(c, 'h80, 'h86)) begin l = 'hd5; c += 'h10; end
            default: ;
        endcase
        g[0] = l[7:0];
        g[1] = c[7:0];
    endfunction

    function automatic bit greek_shift(input int t);
        return span(t, 'h80, 'h87) || span(t, 'h90, 'h97) || span(t, 'ha0, 'ha7);
    endfunction

    // Rewrite a three-byte group in place.
    function automatic void fold_three(ref t_byte g [4]);
        int l;
        int s;
        int t;
        l = g[0];
        s = g[1];
        t = g[2];
        if (l == LeadE1) begin
            case (s)
                'h83: if (span(t, 'h90, 'hba) || span(t, 'hbd, 'hbf)) s = 'hb2;
                'h8f: if (span(t, 'hb8, 'hbd)) t -= 'h08;
                'hb6: if (t == 'h8e) begin l = 'hea; s = 'h9f; t = 'h86; end
                'hb8, 'hb9, 'hbb: if (span(t, 'h80, 'hbf) && is_odd(t)) t--;
                'hba: if ((span(t, 'h80, 'h93) || span(t, 'ha0, 'hbf)) && is_odd(t)) t--;
                'hbc: if (greek_shift(t) || span(t, 'hb0, 'hb7)) t += 'h08;
                'hbd: begin
                    if (span(t, 'h80, 'h87) || (span(t, 'h90, 'h97) && is_odd(t)) ||
                        span(t, 'ha0, 'ha7)) t += 'h08;
                    else if (span(t, 'hb0, 'hb1)) begin s = 'hbe; t += 'h0a; end
                    else if (span(t, 'hb2, 'hb5)) begin s = 'hbf; t -= 'h2a; end
                    else if (span(t, 'hb6, 'hb7)) begin s = 'hbf; t -= 'h1e; end
                    else if (span(t, 'hb8, 'hb9)) s = 'hbf;
                    else if (span(t, 'hba, 'hbb)) begin s = 'hbf; t -= 'h10; end
                    else if (span(t, 'hbc, 'hbd)) begin s = 'hbf; t -= 'h02; end
                end
                'hbe: begin
                    if (greek_shift(t) || span(t, 'hb0, 'hb1)) t += 'h08;
                    else if (t == 'hb3) t += 'h09;
                end
                'hbf: begin
                    if (t == 'h83 || t == 'hb3) t += 'h09;
                    else if (span(t, 'h90, 'h91) || span(t, 'ha0, 'ha1)) t += 'h08;
                    else if (t == 'ha5) t += 'h07;
                end
                default: ;
            endcase
        end else if (l == LeadE2) begin
            case (s)
                'hb0: if (span(t, 'hb0, 'hbf)) t -= 'h30;
                'hb1: begin
                    if (span(t, 'h80, 'h9e)) begin s = 'hb0; t += 'h10; end
                    else if (t == 'ha1 || t == 'ha8 || t == 'haa || t == 'hac || t == 'hb3 ||
                             t == 'hb6) t--;
                end
                'hb2: if (span(t, 'h80, 'hbf) && is_odd(t)) t--;
                'hb3: begin
                    if ((span(t, 'h80, 'ha3) && is_odd(t)) || t == 'hac || t == 'hae ||
                        t == 'hb3) t--;
                end
                default: ;
            endcase
        end else if (l == LeadEa) begin
            case (s)
                'h99: if (span(t, 'h80, 'had) && is_odd(t)) t--;
                'h9a: if (span(t, 'h80, 'h9b) && is_odd(t)) t--;
                'h9c: if ((span(t, 'ha2, 'haf) || span(t, 'hb2, 'hbf)) && is_odd(t)) t--;
                'h9d: begin
                    if ((span(t, 'h80, 'haf) && is_odd(t)) || t == 'hba || t == 'hbc ||
                        t == 'hbf) t--;
                end
                'h9e: begin
                    if (((span(t, 'h80, 'h87) || span(t, 'h96, 'ha9) || span(t, 'hb4, 'hbf)) &&
                         is_odd(t)) || t == 'h8c || t == 'h91 || t == 'h93) t--;
                    else if (t == 'h94) begin s = 'h9f; t = 'h84; end
                end
                'h9f: if (t == 'h83 || t == 'h88 || t == 'h8a || t == 'hb6) t--;
                'had: begin
                    if (t == 'h93) begin s = 'h9e; t = 'hb3; end
                    else if (span(t, 'hb0, 'hbf)) begin l = 'he1; s = 'h8e; t -= 'h10; end
                end
                'hae: begin
                    if (span(t, 'h80, 'h8f)) begin l = 'he1; s = 'h8e; t += 'h30; end
                    else if (span(t, 'h90, 'hbf)) begin l = 'he1; s = 'h8f; t -= 'h10; end
                end
                default: ;
            endcase
        end else if (l == LeadEf) begin
            if (s == 'hbd && span(t, 'h81, 'h9a)) begin s = 'hbc; t += 'h20; end
        end
        g[0] = l[7:0];
        g[1] = s[7:0];
        g[2] = t[7:0];
    endfunction

    // Rewrite a four-byte group in place.
    function automatic void fold_four(ref t_byte g [4]);
        int s;
        int t;
        int u;
        s = g[1];
        t = g[2];
        u = g[3];
        if (s == 'h90) begin
            if (t == 'h90) begin
                if (span(u, 'ha8, 'hbf)) u -= 'h28;
            end else if (t == 'h91) begin
                if (span(u, 'h80, 'h8f)) begin t = 'h90; u += 'h18; end
            end else if (t == 'h93) begin
                if (span(u, 'h98, 'ha7)) begin t = 'h92; u += 'h18; end
                else if (span(u, 'ha8, 'hbb)) u -= 'h28;
            end else if (t == 'hb3) begin
                if (span(u, 'h80, 'hb2)) t = 'hb2;
            end
        end else if (s == 'h91) begin
            if (t == 'ha3 && span(u, 'h80, 'h9f)) begin t = 'ha2; u += 'h20; end
        end else if (s == 'h96) begin
            if (t == 'hb9 && span(u, 'ha0, 'hbf)) u -= 'h20;
        end else if (s == 'h9e) begin
            if (t == 'ha4) begin
                if (span(u, 'ha2, 'hbf)) u -= 'h22;
            end else if (t == 'ha5) begin
                if (span(u, 'h80, 'h83)) begin t = 'ha4; u += 'h1e; end
            end
        end
        g[2] = t[7:0];
        g[3] = u[7:0];
    endfunction

    function automatic void queue_bytes(ref t_byte g [4], input int n, input logic e);
        for (int k = 0; k < n; k++)
            upper_q.insert(upper_q.size(), t_word'{data: g[k], last: (k == n - 1) ? e : 1'b0});
    endfunction

    // Advance the predictor by one accepted word and queue the words it frees.
    function automatic void predict_word(input t_byte b, input logic e);
        t_byte g [4];
        int    h;
        h = grp_held;
        if (h == 0) begin
            if (b > LeadMin) begin
                grp_len = (b == LeadE1 || b == LeadE2 || b == LeadEa || b == LeadEf) ? 3
                        : (b == LeadF0) ? 4 : 2;
                if (e) begin
                    g[0]    = b;
                    grp_len = 0;
                    queue_bytes(g, 1, e);
                end else begin
                    grp_bytes[0] = b;
                    grp_held     = 1;
                end
                return;
            end
            g[0] = (b >= AsciiA && b <= AsciiZ) ? b - CaseStep : b;
            queue_bytes(g, 1, e);
            return;
        end
        // A four-byte lead with a foreign second byte closes as a short group.
        if (grp_bytes[0] == LeadF0 && h == 1 &&
            b != 8'h90 && b != 8'h91 && b != 8'h96 && b != 8'h9e)
            grp_len = 2;
        for (int k = 0; k < h; k++) g[k] = grp_bytes[k];
        g[h] = b;
        if (h + 1 >= grp_len) begin
            if (grp_len == 2 && grp_bytes[0] != LeadF0) fold_two(g);
            else if (grp_len == 3) fold_three(g);
            else if (grp_len == 4) fold_four(g);
            grp_held = 0;
            grp_len  = 0;
            queue_bytes(g, h + 1, e);
        end else if (e) begin
            grp_held = 0;
            grp_len  = 0;
            queue_bytes(g, h + 1, e);
        end else begin
            grp_bytes[h] = b;
            grp_held     = h + 1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender: present one word at the falling edge, hold until taken
    // ------------------------------------------------------------------------
    task automatic send_word(input t_byte b, input logic e);
        if (!steady) begin
            while ($urandom_range(99) < 15) begin
                in_ch.valid = 1'b0;
                @(negedge clk);
            end
        end
        in_ch.valid = 1'b1;
        in_ch.data  = b;
        in_ch.last  = e;
        do @(posedge clk); while (!in_ch.ready);
        predict_word(b, e);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // Receiver: randomize ready at the falling edge, honor any hold-off.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready = 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready = 1'b0;
            hold_left    = hold_left - 1;
        end else begin
            out_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    // Checker: compare each taken word with the oldest expectation.
    always @(posedge clk) begin
        t_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (upper_q.size() == 0) begin
                $display("%0t: unexpected word, actual data=%h last=%b", $time,
                         out_ch.data, out_ch.last);
                fail_count++;
            end else begin
                want = upper_q.pop_front();
                if (out_ch.data !== want.data) begin
                    $display("%0t: data mismatch, expected %h actual %h", $time,
                             want.data, out_ch.data);
                    fail_count++;
                end
                if (out_ch.last !== want.last) begin
                    $display("%0t: last mismatch, expected %b actual %b", $time,
                             want.last, out_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_string(input t_byte s [$], input logic close);
        for (int k = 0; k < s.size(); k++)
            send_word(s[k], close && (k == s.size() - 1));
    endtask

    function automatic t_byte trail_byte();
        return ($urandom_range(9) == 0) ? t_byte'($urandom_range(255))
                                        : t_byte'($urandom_range(8'h80, 8'hbf));
    endfunction

    // Build one well-formed (mostly) character of random kind.
    function automatic void random_char(ref t_byte s [$]);
        t_byte lead3 [4] = '{LeadE1, LeadE2, LeadEa, LeadEf};
        t_byte sec4  [4] = '{8'h90, 8'h91, 8'h96, 8'h9e};
        t_byte thr4  [8] = '{8'h90, 8'h91, 8'h93, 8'hb3, 8'ha3, 8'hb9, 8'ha4, 8'ha5};
        int    kind;
        kind = $urandom_range(9);
        if (kind < 2) begin
            s.insert(s.size(), t_byte'($urandom_range(8'h00, 8'h7f)));
        end else if (kind < 5) begin
            s.insert(s.size(), ($urandom_range(3) == 0) ? t_byte'($urandom_range(8'hc1, 8'hff))
                                                        : t_byte'($urandom_range(8'hc3, 8'hd6)));
            s.insert(s.size(), trail_byte());
        end else if (kind < 7) begin
            s.insert(s.size(), lead3[$urandom_range(3)]);
            s.insert(s.size(), trail_byte());
            s.insert(s.size(), trail_byte());
        end else if (kind < 9) begin
            s.insert(s.size(), LeadF0);
            if ($urandom_range(5) == 0) begin
                s.insert(s.size(), trail_byte());
            end else begin
                s.insert(s.size(), sec4[$urandom_range(3)]);
                s.insert(s.size(), ($urandom_range(1) == 0) ? thr4[$urandom_range(7)]
                                                            : trail_byte());
                s.insert(s.size(), trail_byte());
            end
        end else begin
            s.insert(s.size(), t_byte'($urandom_range(255)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // ASCII range ends, the lead threshold, all group widths, a short
        // four-byte group and strings ending inside or on a group.
        send_string('{8'h00, 8'h60, 8'h61, 8'h7a, 8'h7b, 8'h7f, 8'hc0}, 1'b1);
        send_string('{8'hc3, 8'ha0, 8'hc3, 8'hbf, 8'hd1, 8'h90}, 1'b1);
        send_string('{8'he1, 8'hbd, 8'hb0, 8'hef, 8'hbd, 8'h81}, 1'b1);
        send_string('{8'hf0, 8'h90, 8'h90, 8'ha8, 8'hf0, 8'h41, 8'h62}, 1'b1);
        send_string('{8'he2, 8'hb0}, 1'b1);
        send_string('{8'hff}, 1'b1);
        send_string('{8'hd0, 8'hb0}, 1'b1);
    endtask

    task automatic test_random_strings(input int n_words);
        t_byte s [$];
        int    sent;
        sent = 0;
        while (sent < n_words) begin
            s = {};
            repeat ($urandom_range(1, 6)) random_char(s);
            // Cut some strings short so a group stays open at the end mark.
            if ($urandom_range(4) == 0 && s.size() > 1) void'(s.pop_back());
            send_string(s, $urandom_range(2) == 0);
            sent += s.size();
        end
        send_word(8'h2e, 1'b1);
    endtask

    task automatic test_steady_stream();
        t_byte s [$];
        steady = 1'b1;
        repeat (10) random_char(s);
        send_string(s, 1'b1);
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        t_byte s [$];
        hold_left = 300;
        repeat (8) random_char(s);
        send_string(s, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        in_ch.last   = 1'b0;
        out_ch.ready = 1'b0;
        grp_len      = 0;
        grp_held     = 0;
        fail_count   = 0;
        steady       = 1'b0;
        hold_left    = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_steady_stream();
        test_backpressure();
        test_random_strings(120);

        while (upper_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
